FILE: rtl/wpf_pkg.sv
// Shared constants, register indexes and the arctangent table of the waypoint follower.
package wpf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 256;
  localparam int CORDIC_STEPS      = 24;
  localparam int TURN_GAIN         = 30883;

  localparam logic [2:0] REG_WAYPOINT_TOL = 3'd0;
  localparam logic [2:0] REG_GOAL_TOL     = 3'd1;
  localparam logic [2:0] REG_MAX_TURN     = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd3;
  localparam logic [2:0] REG_ALIGN        = 3'd4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_POSE   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [30:0] WAYPOINT_TOL_RST = 31'd13107;
  localparam logic [30:0] GOAL_TOL_RST     = 31'd6554;
  localparam logic [14:0] MAX_TURN_RST     = 15'd4096;
  localparam logic [30:0] MAX_SPEED_RST    = 31'd32768;
  localparam logic [15:0] ALIGN_RST        = 16'd8192;

  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2F9;
        5'd15: v = 32'h0000517C;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A2F;
        5'd19: v = 32'h00000517;
        5'd20: v = 32'h0000028B;
        5'd21: v = 32'h00000145;
        5'd22: v = 32'h000000A2;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: rtl/wpf_if.sv
// Request and result channel interfaces of the waypoint follower.
interface wpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] waypoint_x;
  logic signed [31:0] waypoint_y;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;
  modport source (output valid, command, waypoint_x, waypoint_y, pose_x, pose_y, pose_heading,
                  input ready);
  modport sink (input valid, command, waypoint_x, waypoint_y, pose_x, pose_y, pose_heading,
                output ready);
endinterface

interface wpf_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        forward_speed;
  logic signed [15:0] turn_rate;
  logic               path_finished;
  logic [8:0]         target_index;
  modport source (output valid, forward_speed, turn_rate, path_finished, target_index,
                  input ready);
  modport sink (input valid, forward_speed, turn_rate, path_finished, target_index,
                output ready);
endinterface

FILE: rtl/wpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/waypoint_path_follower.sv
// Waypoint path follower: waypoint store, reach tests and proportional heading control.
// Clear, append and unused requests are handled in the idle state and give no result.
// A pose request tests waypoints in turn, then runs the square root, normalize, CORDIC and finishing
// states; the squares, root, turn and speed products share one multiplier.
// The block takes no new request until the result of a pose request is registered.
// Synchronous reset clears the path and loads the register reset values; the store needs none.
module waypoint_path_follower #(
  parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wpf_in_if.sink      in_ch,
  wpf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIF   = 4'd2;
  localparam logic [3:0] S_SQX   = 4'd3;
  localparam logic [3:0] S_SQY   = 4'd4;
  localparam logic [3:0] S_SQT   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_NORM  = 4'd7;
  localparam logic [3:0] S_CORD  = 4'd8;
  localparam logic [3:0] S_FOLD  = 4'd9;
  localparam logic [3:0] S_TURN  = 4'd10;
  localparam logic [3:0] S_SPEED = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]  state_r;
  logic [30:0] wtol_r, gtol_r, mfs_r;
  logic [14:0] mtr_r;
  logic [15:0] align_r;
  logic [CW-1:0] count_r, target_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0] head_r;
  logic signed [32:0] dx_r, dy_r;
  logic [32:0] ax_r, ay_r;
  logic        last_r;
  logic [66:0] acc_r;
  logic [30:0] root_r;
  logic [4:0]  k_r;
  logic [31:0] gap_r;
  logic signed [43:0] cx_r, cy_r;
  logic signed [33:0] z_r;
  logic [15:0] aerr_r;
  logic        eneg_r;
  logic signed [15:0] turn_r;
  logic [30:0] speed_r;
  logic        fin_r;
  logic        out_valid_r;
  logic [30:0] out_speed_r;
  logic signed [15:0] out_turn_r;
  logic        out_fin_r;
  logic [8:0]  out_idx_r;

  logic        accept;
  logic        ram_we;
  logic [63:0] ram_rdata;
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [30:0] root_try, root_new;
  logic signed [32:0] dx_c, dy_c;
  logic signed [43:0] xs, ys;
  logic signed [33:0] zc;
  logic [31:0] zu, fold_a, fold_r;
  logic [15:0] bear, err;
  logic [15:0] q, qc;
  logic [30:0] term;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign ram_we = accept && (in_ch.command == wpf_pkg::CMD_APPEND) &&
                  (count_r < CW'(MAX_WAYPOINTS));

  wpf_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_ch.waypoint_y, in_ch.waypoint_x}),
    .raddr (target_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    root_try = root_r | (31'd1 << k_r);
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQX:   begin mul_a = ax_r; mul_b = ax_r; end
      S_SQY:   begin mul_a = ay_r; mul_b = ay_r; end
      S_SQT:   begin
        mul_a = {2'b0, (last_r ? gtol_r : wtol_r)};
        mul_b = {2'b0, (last_r ? gtol_r : wtol_r)};
      end
      S_SQRT:  begin mul_a = {2'b0, root_try}; mul_b = {2'b0, root_try}; end
      S_TURN:  begin mul_a = {17'b0, aerr_r}; mul_b = 33'(wpf_pkg::TURN_GAIN); end
      S_SPEED: begin mul_a = {2'b0, mfs_r}; mul_b = 33'(17'd32768 - {1'b0, aerr_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign root_new = ({1'b0, prod} <= acc_r) ? root_try : root_r;

  assign dx_c = 33'(signed'(ram_rdata[31:0])) - 33'(px_r);
  assign dy_c = 33'(signed'(ram_rdata[63:32])) - 33'(py_r);

  assign xs = cx_r >>> k_r;
  assign ys = cy_r >>> k_r;

  always_comb begin
    zc = z_r;
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > 34'sh40000000) begin
      zc = 34'sh40000000;
    end
    zu = zc[31:0];
    if (!dx_r[32]) begin
      fold_a = dy_r[32] ? (32'd0 - zu) : zu;
    end else begin
      fold_a = dy_r[32] ? (32'h80000000 + zu) : (32'h80000000 - zu);
    end
    fold_r = fold_a + 32'h8000;
    bear = (dx_r == '0 && dy_r == '0) ? 16'd0 : fold_r[31:16];
    err = bear - head_r;
  end

  always_comb begin
    q = prod[31:16] + 16'(prod[15]);
    qc = (q > {1'b0, mtr_r}) ? {1'b0, mtr_r} : q;
    term = prod[45:15];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
      wtol_r      <= wpf_pkg::WAYPOINT_TOL_RST;
      gtol_r      <= wpf_pkg::GOAL_TOL_RST;
      mtr_r       <= wpf_pkg::MAX_TURN_RST;
      mfs_r       <= wpf_pkg::MAX_SPEED_RST;
      align_r     <= wpf_pkg::ALIGN_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wpf_pkg::REG_WAYPOINT_TOL: wtol_r  <= cfg_data;
          wpf_pkg::REG_GOAL_TOL:     gtol_r  <= cfg_data;
          wpf_pkg::REG_MAX_TURN:     mtr_r   <= cfg_data[14:0];
          wpf_pkg::REG_MAX_SPEED:    mfs_r   <= cfg_data;
          wpf_pkg::REG_ALIGN:        align_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_ch.command)
              wpf_pkg::CMD_CLEAR: begin
                count_r  <= '0;
                target_r <= '0;
              end
              wpf_pkg::CMD_APPEND: begin
                if (ram_we) begin
                  count_r <= count_r + CW'(1);
                end
              end
              wpf_pkg::CMD_POSE: begin
                px_r    <= in_ch.pose_x;
                py_r    <= in_ch.pose_y;
                head_r  <= in_ch.pose_heading;
                state_r <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (target_r < count_r) begin
            state_r <= S_DIF;
          end else begin
            speed_r <= '0;
            turn_r  <= '0;
            fin_r   <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_DIF: begin
          dx_r    <= dx_c;
          dy_r    <= dy_c;
          ax_r    <= dx_c[32] ? 33'(-dx_c) : dx_c;
          ay_r    <= dy_c[32] ? 33'(-dy_c) : dy_c;
          last_r  <= (target_r + CW'(1) == count_r);
          state_r <= S_SQX;
        end
        S_SQX: begin
          acc_r   <= {1'b0, prod};
          state_r <= S_SQY;
        end
        S_SQY: begin
          acc_r   <= acc_r + {1'b0, prod};
          state_r <= S_SQT;
        end
        S_SQT: begin
          if (acc_r < {1'b0, prod}) begin
            target_r <= target_r + CW'(1);
            state_r  <= S_RD;
          end else begin
            cx_r   <= 44'(ax_r);
            cy_r   <= 44'(ay_r);
            root_r <= '0;
            k_r    <= 5'd30;
            if (acc_r >= (67'd1 << 62)) begin
              gap_r   <= 32'h80000000;
              state_r <= S_NORM;
            end else begin
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          root_r <= root_new;
          if (k_r == 5'd0) begin
            gap_r   <= {1'b0, root_new};
            state_r <= S_NORM;
          end else begin
            k_r <= k_r - 5'd1;
          end
        end
        S_NORM: begin
          if (cx_r == '0 && cy_r == '0) begin
            state_r <= S_FOLD;
          end else if (cx_r < 44'sh8000000000 && cy_r < 44'sh8000000000) begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
          end else begin
            z_r     <= '0;
            k_r     <= '0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            z_r  <= z_r + 34'(wpf_pkg::atan_step(k_r));
          end else begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            z_r  <= z_r - 34'(wpf_pkg::atan_step(k_r));
          end
          if (k_r == 5'(wpf_pkg::CORDIC_STEPS - 1)) begin
            state_r <= S_FOLD;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_FOLD: begin
          eneg_r  <= err[15];
          aerr_r  <= err[15] ? (16'd0 - err) : err;
          state_r <= S_TURN;
        end
        S_TURN: begin
          turn_r  <= eneg_r ? (16'sd0 - signed'(qc)) : signed'(qc);
          state_r <= S_SPEED;
        end
        S_SPEED: begin
          if (aerr_r < align_r) begin
            speed_r <= (gap_r < {1'b0, term}) ? gap_r[30:0] : term;
          end else begin
            speed_r <= '0;
          end
          fin_r   <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_speed_r <= speed_r;
            out_turn_r  <= turn_r;
            out_fin_r   <= fin_r;
            out_idx_r   <= 9'(target_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.forward_speed = out_speed_r;
  assign out_ch.turn_rate     = out_turn_r;
  assign out_ch.path_finished = out_fin_r;
  assign out_ch.target_index  = out_idx_r;

  a_target_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    target_r <= count_r) else $error("tracked index passed the loaded count");

  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_WAYPOINTS)) else $error("loaded count beyond capacity");

  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_speed_r == '0 && out_turn_r == '0)
    else $error("finished path gave motion");

  a_turn_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_turn_r <= signed'({1'b0, mtr_r})) &&
                    (out_turn_r >= 16'sd0 - signed'({1'b0, mtr_r})))
    else $error("turn rate outside its limit");
endmodule

FILE: sim/wpf_guidance_checker.sv
// Checker that predicts the guidance outputs of the waypoint follower and compares them.
`timescale 1ns / 100ps

module wpf_guidance_checker (
  input  logic        clk,
  input  logic        rst_n,
  wpf_in_if           in_ch,
  wpf_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  localparam int DEPTH = wpf_pkg::MAX_WAYPOINTS_DEF;

  typedef struct packed {
    logic [30:0]        speed;
    logic signed [15:0] turn;
    logic               finished;
    logic [8:0]         target;
  } guidance_t;

  localparam logic [31:0] ARCTAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

  logic signed [31:0] route_x [DEPTH];
  logic signed [31:0] route_y [DEPTH];
  int                 route_len;
  int                 tracked;
  logic [30:0]        wp_tol, goal_tol, turn_cap, speed_cap;
  logic [15:0]        align_lim;
  guidance_t          expected_q [$];

  function automatic logic [66:0] range_sq(longint dx, longint dy);
    logic [66:0] ax, ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    return ax * ax + ay * ay;
  endfunction

  function automatic logic [31:0] range_of(logic [66:0] s);
    logic [66:0] r, t;
    r = '0;
    if (s >= (67'd1 << 62)) return 32'h80000000;
    for (int b = 30; b >= 0; b--) begin
      t = r | (67'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[31:0];
  endfunction

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    longint      ax, ay, x, y, z, xs, ys;
    logic [31:0] zu, a, t;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax == 0 && ay == 0) return 16'd0;
    while (((ax > ay) ? ax : ay) < (longint'(1) << 39)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = ax;
    y = ay;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ARCTAN[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ARCTAN[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sh40000000) z = 64'sh40000000;
    zu = z[31:0];
    if (dx >= 0) a = (dy >= 0) ? zu : 32'd0 - zu;
    else a = (dy >= 0) ? 32'h80000000 - zu : 32'h80000000 + zu;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic guidance_t steer_toward(logic signed [31:0] px, logic signed [31:0] py,
                                             logic [15:0] head);
    guidance_t          g;
    logic [66:0]        tol;
    longint             dx, dy, term;
    logic [31:0]        gap;
    logic signed [15:0] err;
    int                 aerr, q, turn;
    while (tracked < route_len && tracked < DEPTH) begin
      tol = (tracked + 1 == route_len) ? goal_tol : wp_tol;
      if (range_sq(longint'(route_x[tracked]) - longint'(px),
                   longint'(route_y[tracked]) - longint'(py)) >= tol * tol) break;
      tracked++;
    end
    g = '0;
    g.target = tracked[8:0];
    if (tracked >= route_len) begin
      g.finished = 1'b1;
      return g;
    end
    dx = longint'(route_x[tracked]) - longint'(px);
    dy = longint'(route_y[tracked]) - longint'(py);
    gap = range_of(range_sq(dx, dy));
    err = bearing_of(dx, dy) - head;
    aerr = (err < 0) ? -int'(err) : int'(err);
    q = (aerr * wpf_pkg::TURN_GAIN + 32768) >>> 16;
    turn = (err < 0) ? -q : q;
    if (turn > int'(turn_cap)) turn = int'(turn_cap);
    if (turn < -int'(turn_cap)) turn = -int'(turn_cap);
    g.turn = turn[15:0];
    if (aerr < int'(align_lim)) begin
      term = (longint'(speed_cap) * (32768 - aerr)) >>> 15;
      g.speed = (longint'(gap) < term) ? gap[30:0] : term[30:0];
    end
    return g;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    guidance_t want;
    if (!rst_n) begin
      route_len = 0;
      tracked = 0;
      wp_tol = wpf_pkg::WAYPOINT_TOL_RST;
      goal_tol = wpf_pkg::GOAL_TOL_RST;
      turn_cap = 31'(wpf_pkg::MAX_TURN_RST);
      speed_cap = wpf_pkg::MAX_SPEED_RST;
      align_lim = wpf_pkg::ALIGN_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wpf_pkg::REG_WAYPOINT_TOL: wp_tol = cfg_data;
          wpf_pkg::REG_GOAL_TOL:     goal_tol = cfg_data;
          wpf_pkg::REG_MAX_TURN:     turn_cap = {16'd0, cfg_data[14:0]};
          wpf_pkg::REG_MAX_SPEED:    speed_cap = cfg_data;
          wpf_pkg::REG_ALIGN:        align_lim = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          wpf_pkg::CMD_CLEAR: begin
            route_len = 0;
            tracked = 0;
          end
          wpf_pkg::CMD_APPEND: begin
            if (route_len < DEPTH) begin
              route_x[route_len] = in_ch.waypoint_x;
              route_y[route_len] = in_ch.waypoint_y;
              route_len++;
            end
          end
          wpf_pkg::CMD_POSE: begin
            expected_q.push_back(steer_toward(in_ch.pose_x, in_ch.pose_y,
                                              in_ch.pose_heading));
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report("unexpected result, speed", out_ch.forward_speed, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.forward_speed !== want.speed)
            report("forward_speed", out_ch.forward_speed, want.speed);
          if (out_ch.turn_rate !== want.turn)
            report("turn_rate", out_ch.turn_rate, want.turn);
          if (out_ch.path_finished !== want.finished)
            report("path_finished", out_ch.path_finished, want.finished);
          if (out_ch.target_index !== want.target)
            report("target_index", out_ch.target_index, want.target);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/waypoint_path_follower_test.sv
// Top of the waypoint follower test: clock, reset, requests, register settings and verdict.
`timescale 1ns / 100ps

module waypoint_path_follower_test;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_data;
  int          fail_count, pending, result_count;
  int          requests, settings;
  bit          hold_req;
  int          cur_tol;
  int          aim;
  logic signed [31:0] path_x [$];
  logic signed [31:0] path_y [$];

  wpf_in_if  in_ch ();
  wpf_out_if out_ch ();

  waypoint_path_follower u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  wpf_guidance_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [31:0] near(logic signed [31:0] v, int spread);
    int s;
    s = (spread > (1 << 24)) ? (1 << 24) : spread;
    return v + $signed($urandom_range(0, 2 * s)) - s;
  endfunction

  task automatic offer(logic [1:0] cmd, logic [31:0] wx, logic [31:0] wy,
                       logic [31:0] px, logic [31:0] py, logic [31:0] head);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.command <= cmd;
    in_ch.waypoint_x <= wx;
    in_ch.waypoint_y <= wy;
    in_ch.pose_x <= px;
    in_ch.pose_y <= py;
    in_ch.pose_heading <= head[15:0];
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests++;
  endtask

  task automatic clear_path();
    offer(wpf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    path_x.delete();
    path_y.delete();
    aim = 0;
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    offer(wpf_pkg::CMD_APPEND, x, y, $urandom, $urandom, $urandom);
    if (path_x.size() < wpf_pkg::MAX_WAYPOINTS_DEF) begin
      path_x.push_back(x);
      path_y.push_back(y);
    end
  endtask

  task automatic pose(logic [31:0] x, logic [31:0] y, logic [31:0] head);
    offer(wpf_pkg::CMD_POSE, $urandom, $urandom, x, y, head);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic setup(logic [30:0] wtol, logic [30:0] gtol, logic [30:0] turn,
                       logic [30:0] speed, logic [30:0] align);
    write_reg(wpf_pkg::REG_WAYPOINT_TOL, wtol);
    write_reg(wpf_pkg::REG_GOAL_TOL, gtol);
    write_reg(wpf_pkg::REG_MAX_TURN, turn);
    write_reg(wpf_pkg::REG_MAX_SPEED, speed);
    write_reg(wpf_pkg::REG_ALIGN, align);
    cfg_we <= 1'b0;
    cur_tol = int'(wtol);
    settings++;
  endtask

  function automatic logic [30:0] pick_value(logic [30:0] hi, logic [30:0] typical);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 31'd0;
    if (r < 30) return hi;
    return 31'($urandom_range(0, typical));
  endfunction

  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        held = 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if ($urandom_range(0, 9) < 7 && !(hold_req && !held)) begin
          out_ch.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #200000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int n, m, r, spread, idx;
    bit big_done;
    logic signed [31:0] bx, by;
    requests = 0;
    settings = 0;
    hold_req = 1'b0;
    big_done = 1'b0;
    cur_tol = 13107;
    aim = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= wpf_pkg::CMD_CLEAR;
    in_ch.waypoint_x <= '0;
    in_ch.waypoint_y <= '0;
    in_ch.pose_x <= '0;
    in_ch.pose_y <= '0;
    in_ch.pose_heading <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pose(0, 0, 0);
    offer(wpf_pkg::CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    add_point(0, 0);
    add_point(32'h7FFFFFFF, 32'h80000000);
    add_point(32'h80000000, 32'h7FFFFFFF);
    pose(0, 0, 32'h7FFF);
    pose(32'h80000000, 32'h7FFFFFFF, 32'h8000);
    pose(32'h7FFFFFFF, 32'h80000000, 0);
    pose(32'h80000000, 32'h7FFFFFFF, 0);
    clear_path();
    add_point(65536, 0);
    pose(0, 0, 32'h8000);
    pose(0, 0, 0);
    pose(0, 65536, 32'h4000);
    pose(65536 + 5000, 0, 0);
    settle();
    setup(0, 0, 31'd32767, 31'h7FFFFFFF, 31'd32768);
    clear_path();
    add_point(1000, 1000);
    pose(1000, 1000, 0);
    pose(0, 0, 32'h2000);
    add_point(-7000, 123456);
    pose(-7000, 123456, 32'hC000);
    settle();
    setup(31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 0);
    clear_path();
    add_point(300000, -300000);
    add_point(32'h80000000, 32'h80000000);
    pose(0, 0, 0);

    while (requests < 1850) begin
      settle();
      case (settings)
        3: setup(31'h7FFFFFFF, 31'h7FFFFFFF, 31'd32767, 31'h7FFFFFFF, 31'd32768);
        4: setup(0, 0, 0, 0, 0);
        default: setup(pick_value(31'h7FFFFFFF, 1 << 18), pick_value(31'h7FFFFFFF, 1 << 18),
                       pick_value(31'd32767, 32767), pick_value(31'h7FFFFFFF, 1 << 21),
                       pick_value(31'd32768, 32768));
      endcase
      for (int k = 0; k < 3; k++) begin
        clear_path();
        r = $urandom_range(0, 99);
        if (!big_done && settings == 5) begin
          n = 260;
          big_done = 1'b1;
        end else if (r < 90) n = $urandom_range(1, 6);
        else n = $urandom_range(7, 30);
        bx = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        by = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 9) == 0) add_point($urandom, $urandom);
          else add_point(near(bx, 1 << 20), near(by, 1 << 20));
        end
        if (settings == 6 && k == 0) hold_req = 1'b1;
        m = 2 * ((n > 30) ? 30 : n) + 3;
        for (int j = 0; j < m; j++) begin
          r = $urandom_range(0, 99);
          if (r < 75 && path_x.size() > 0) begin
            idx = (aim < path_x.size()) ? aim : path_x.size() - 1;
            case ($urandom_range(0, 4))
              0: spread = 0;
              1: spread = cur_tol / 2;
              2: spread = cur_tol;
              3: spread = (cur_tol > (1 << 22)) ? (1 << 23) : 2 * cur_tol + 1;
              default: spread = 1 << $urandom_range(0, 24);
            endcase
            pose(near(path_x[idx], spread), near(path_y[idx], spread), $urandom);
            if ($urandom_range(0, 1) == 1) aim++;
          end else if (r < 87) begin
            pose($urandom, $urandom, $urandom);
          end else begin
            case ($urandom_range(0, 3))
              0: clear_path();
              1: add_point($urandom, $urandom);
              2: pose($urandom, $urandom, $urandom);
              default: offer(wpf_pkg::CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
            endcase
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d requests under %0d register settings; %0d guidance results checked.",
             requests, settings, result_count);
    $display("Runs included empty and exhausted paths, full store overflow and a long output stall.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wpf_pkg.sv
rtl/wpf_if.sv
rtl/wpf_ram.sv
rtl/waypoint_path_follower.sv
sim/wpf_guidance_checker.sv
sim/waypoint_path_follower_test.sv
